// ===== hdl/sm83alu_pkg.sv =====
package sm83alu_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned FlagW   = 4;
    localparam int unsigned OpW     = 5;
    localparam int unsigned BitIdxW = 3;

    // flag bit positions in a z n h c nibble
    localparam int unsigned FlagZ = 3;
    localparam int unsigned FlagN = 2;
    localparam int unsigned FlagH = 1;
    localparam int unsigned FlagC = 0;

    // DAA adjust constants
    localparam logic [ByteW-1:0] DaaSubLow  = 8'hFA;
    localparam logic [ByteW-1:0] DaaSubHigh = 8'hA0;
    localparam logic [ByteW-1:0] DaaAddLow  = 8'h06;
    localparam logic [ByteW-1:0] DaaAddHigh = 8'h60;
    localparam logic [ByteW-1:0] DaaMaxBcd  = 8'h99;
    localparam logic [3:0]       DaaMaxDig  = 4'h9;

    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 16;

    typedef enum logic [OpW-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_SLA  = 5'd14,
        OP_SRA  = 5'd15,
        OP_SWAP = 5'd16,
        OP_SRL  = 5'd17,
        OP_BIT  = 5'd18,
        OP_RES  = 5'd19,
        OP_SET  = 5'd20,
        OP_DAA  = 5'd21,
        OP_CPL  = 5'd22,
        OP_SCF  = 5'd23,
        OP_CCF  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28
    } op_t;

    typedef struct packed {
        logic [OpW-1:0]     operation;
        logic [ByteW-1:0]   operand_a;
        logic [ByteW-1:0]   operand_b;
        logic [BitIdxW-1:0] bit_index;
        logic [FlagW-1:0]   flags_in;
    } alu_in_t;

    typedef struct packed {
        logic [ByteW-1:0] result;
        logic [FlagW-1:0] flags_out;
        logic             writes_result;
    } alu_out_t;

endpackage

// ===== hdl/sm83alu_core.sv =====
module sm83alu_core (
    input  sm83alu_pkg::alu_in_t  alu_in,
    output sm83alu_pkg::alu_out_t alu_out
);
    import sm83alu_pkg::*;

    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic             fz;
    logic             fn;
    logic             fh;
    logic             fc;
    logic             t;
    logic [ByteW:0]   sum9;
    logic [4:0]       half5;
    logic [ByteW-1:0] r;
    logic [FlagW-1:0] nf;
    logic             wr;
    logic [ByteW-1:0] mask;
    logic             daa_hi;
    logic             daa_lo;

    assign a  = alu_in.operand_a;
    assign b  = alu_in.operand_b;
    assign fz = alu_in.flags_in[FlagZ];
    assign fn = alu_in.flags_in[FlagN];
    assign fh = alu_in.flags_in[FlagH];
    assign fc = alu_in.flags_in[FlagC];
    assign mask = ByteW'(1) << alu_in.bit_index;
    assign daa_hi = fc || (a > DaaMaxBcd);
    assign daa_lo = fh || (a[3:0] > DaaMaxDig);

    always_comb
    begin
        r     = a;
        nf    = alu_in.flags_in;
        wr    = 1'b1;
        t     = 1'b0;
        sum9  = '0;
        half5 = '0;
        unique case (op_t'(alu_in.operation)) inside
            OP_ADD, OP_ADC:
            begin
                t     = (op_t'(alu_in.operation) == OP_ADC) ? fc : 1'b0;
                sum9  = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, t};
                half5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
                r     = sum9[ByteW-1:0];
                nf    = {r == '0, 1'b0, half5[4], sum9[ByteW]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                t     = (op_t'(alu_in.operation) == OP_SBC) ? fc : 1'b0;
                sum9  = {1'b0, a} - {1'b0, b} - {{ByteW{1'b0}}, t};
                half5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};
                r     = sum9[ByteW-1:0];
                nf    = {r == '0, 1'b1, half5[4], sum9[ByteW]};
                if (op_t'(alu_in.operation) == OP_CP)
                begin
                    r  = a;
                    wr = 1'b0;
                end
            end
            OP_AND:
            begin
                r  = a & b;
                nf = {r == '0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                r  = a ^ b;
                nf = {r == '0, 3'b000};
            end
            OP_OR:
            begin
                r  = a | b;
                nf = {r == '0, 3'b000};
            end
            OP_INC:
            begin
                r  = a + ByteW'(1);
                nf = {r == '0, 1'b0, a[3:0] == 4'hF, fc};
            end
            OP_DEC:
            begin
                r  = a - ByteW'(1);
                nf = {r == '0, 1'b1, a[3:0] == 4'h0, fc};
            end
            OP_RLC, OP_RLCA:
            begin
                r  = {a[ByteW-2:0], a[ByteW-1]};
                nf = {(op_t'(alu_in.operation) == OP_RLC) && (r == '0), 2'b00, a[ByteW-1]};
            end
            OP_RRC, OP_RRCA:
            begin
                r  = {a[0], a[ByteW-1:1]};
                nf = {(op_t'(alu_in.operation) == OP_RRC) && (r == '0), 2'b00, a[0]};
            end
            OP_RL, OP_RLA:
            begin
                r  = {a[ByteW-2:0], fc};
                nf = {(op_t'(alu_in.operation) == OP_RL) && (r == '0), 2'b00, a[ByteW-1]};
            end
            OP_RR, OP_RRA:
            begin
                r  = {fc, a[ByteW-1:1]};
                nf = {(op_t'(alu_in.operation) == OP_RR) && (r == '0), 2'b00, a[0]};
            end
            OP_SLA:
            begin
                r  = {a[ByteW-2:0], 1'b0};
                nf = {r == '0, 2'b00, a[ByteW-1]};
            end
            OP_SRA:
            begin
                r  = {a[ByteW-1], a[ByteW-1:1]};
                nf = {r == '0, 2'b00, a[0]};
            end
            OP_SWAP:
            begin
                r  = {a[3:0], a[ByteW-1:4]};
                nf = {r == '0, 3'b000};
            end
            OP_SRL:
            begin
                r  = {1'b0, a[ByteW-1:1]};
                nf = {r == '0, 2'b00, a[0]};
            end
            OP_BIT:
            begin
                nf = {(a & mask) == '0, 1'b0, 1'b1, fc};
                wr = 1'b0;
            end
            OP_RES:
                r = a & ~mask;
            OP_SET:
                r = a | mask;
            OP_DAA:
            begin
                t = fc;
                if (fn)
                begin
                    if (fh)
                        r = r + DaaSubLow;
                    if (fc)
                        r = r + DaaSubHigh;
                end
                else
                begin
                    if (daa_hi)
                    begin
                        r = r + DaaAddHigh;
                        t = 1'b1;
                    end
                    if (daa_lo)
                        r = r + DaaAddLow;
                end
                nf = {r == '0, fn, 1'b0, t};
            end
            OP_CPL:
            begin
                r  = ~a;
                nf = {fz, 1'b1, 1'b1, fc};
            end
            OP_SCF:
            begin
                nf = {fz, 2'b00, 1'b1};
                wr = 1'b0;
            end
            OP_CCF:
            begin
                nf = {fz, 2'b00, ~fc};
                wr = 1'b0;
            end
            default:
                wr = 1'b0;
        endcase
    end

    assign alu_out.result        = r;
    assign alu_out.flags_out     = nf;
    assign alu_out.writes_result = wr;

endmodule

// ===== hdl/sm83_alu_with_flags.sv =====
// channel  | direction | tdata (low bit up)                               | tuser
// s_axis   | in        | operand_a[7:0] operand_b[15:8] bit_index[18:16]  | operation[4:0]
//          |           | flags_in[22:19] zero[23]                         |
// m_axis   | out       | result[7:0] flags_out[11:8] writes_result[12]    | -
//          |           | zero[15:13]                                      |
// Two-stage pipeline: input register, ALU logic, result register.
// m_axis_tvalid is out_reg's valid bit; one transaction per cycle absent an m_axis stall.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on m_axis holds the result stage and a full input stage; a stage refills in the cycle it drains.
module sm83_alu_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // operand_a, operand_b, bit_index, flags_in, pad
    input  logic [4:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // result, flags_out, writes_result, pad
);
    import sm83alu_pkg::*;

    alu_in_t  in_reg;
    alu_in_t  in_next;
    logic     in_valid_reg;
    alu_out_t out_reg;
    alu_out_t alu_res;
    logic     out_valid_reg;
    logic     out_load;
    logic     in_load;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign in_next.operation = s_axis_tuser;
    assign in_next.operand_a = s_axis_tdata[7:0];
    assign in_next.operand_b = s_axis_tdata[15:8];
    assign in_next.bit_index = s_axis_tdata[18:16];
    assign in_next.flags_in  = s_axis_tdata[22:19];

    sm83alu_core u_core (
        .alu_in  (in_reg),
        .alu_out (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_reg <= in_next;
        if (out_load && in_valid_reg)
            out_reg <= alu_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.writes_result, out_reg.flags_out, out_reg.result};

endmodule
